// ----- design/bos_pkg.sv -----
// Shared types and constants for the buffer overload supervisor.
// Depends on nothing; every other design file imports it.
package bos_pkg;

    // Field widths
    localparam int LEVEL_W   = 16;
    localparam int FLUSH_W   = 8;
    localparam int CALM_W    = 16;
    localparam int SLEEP_W   = 16;
    localparam int ELAPSED_W = SLEEP_W + 1;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // Saturation limits of the counters
    localparam logic [CALM_W-1:0]    CALM_MAX    = '1;
    localparam logic [FLUSH_W-1:0]   FLUSH_MAX   = '1;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

    // Register values after reset
    localparam logic signed [LEVEL_W-1:0] STOP_LEVEL_RST    = 16'sd100;
    localparam logic signed [LEVEL_W-1:0] FLUSH_LEVEL_RST   = 16'sd200;
    localparam logic [FLUSH_W-1:0]        FLUSH_LIMIT_RST   = 8'd3;
    localparam logic [CALM_W-1:0]         CALM_NEEDED_RST   = 16'd10;
    localparam logic [SLEEP_W-1:0]        SLEEP_SECONDS_RST = 16'd60;

    // Request kinds
    localparam logic REQ_LEVEL = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STOP_LEVEL    = 3'd0,
        CFG_FLUSH_LEVEL   = 3'd1,
        CFG_FLUSH_LIMIT   = 3'd2,
        CFG_CALM_NEEDED   = 3'd3,
        CFG_SLEEP_SECONDS = 3'd4
    } cfg_index_t;

    // One result beat
    typedef struct packed {
        logic               stop_motion;
        logic               resume_motion;
        logic               flush_request;
        logic               halt_locator;
        logic               restart_locator;
        logic               fault_active;
        logic               locator_asleep;
        logic [FLUSH_W-1:0] flush_total;
    } result_t;

endpackage

// ----- design/bos_if.sv -----
// Channel interfaces of the buffer overload supervisor: request, result, configuration.
// Depends on bos_pkg for field widths.
interface bos_req_if;
    import bos_pkg::*;
    logic                       valid;
    logic                       ready;
    logic                       req_type;
    logic signed [LEVEL_W-1:0]  level;
    modport source (output valid, req_type, level, input ready);
    modport sink   (input valid, req_type, level, output ready);
endinterface

interface bos_rsp_if;
    import bos_pkg::*;
    logic               valid;
    logic               ready;
    logic               stop_motion;
    logic               resume_motion;
    logic               flush_request;
    logic               halt_locator;
    logic               restart_locator;
    logic               fault_active;
    logic               locator_asleep;
    logic [FLUSH_W-1:0] flush_total;
    modport source (output valid, stop_motion, resume_motion, flush_request, halt_locator,
                    restart_locator, fault_active, locator_asleep, flush_total,
                    input ready);
    modport sink   (input valid, stop_motion, resume_motion, flush_request, halt_locator,
                    restart_locator, fault_active, locator_asleep, flush_total,
                    output ready);
endinterface

interface bos_cfg_if;
    import bos_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/buffer_overload_supervisor.sv -----
// Buffer overload supervisor: level reports and ticks in, motion/locator commands out.
// Depends on bos_pkg and the channel interfaces in bos_if.sv.
//
//   channel  dir  payload                                   handshake
//   req      in   req_type, level                           valid/ready
//   rsp      out  command bits, fault/sleep flags, flushes  valid/ready
//   cfg      in   index, data                               valid/ready (always ready)
//
// For each request beat, the supervisor state and the result register
// are updated at the accepting edge, and the result is offered in the next cycle.
// One request beat can be accepted every cycle; the single result register is the
// only buffering, so req.ready drops while a result waits and rsp.ready is low.
// Reset clears the flags and counters and loads the default thresholds.
module buffer_overload_supervisor (
    input  logic  clk,
    input  logic  rst_n,
    bos_req_if.sink   req,
    bos_rsp_if.source rsp,
    bos_cfg_if.sink   cfg
);
    import bos_pkg::*;

    // Configuration registers
    logic signed [LEVEL_W-1:0] stop_level_reg;
    logic signed [LEVEL_W-1:0] flush_level_reg;
    logic [FLUSH_W-1:0]        flush_limit_reg;
    logic [CALM_W-1:0]         calm_needed_reg;
    logic [SLEEP_W-1:0]        sleep_seconds_reg;

    // Supervisor state
    logic                 fault_reg, fault_next;
    logic                 asleep_reg, asleep_next;
    logic [FLUSH_W-1:0]   flush_reg, flush_next;
    logic [CALM_W-1:0]    calm_reg, calm_next;
    logic [ELAPSED_W-1:0] elapsed_reg, elapsed_next;

    // Result register
    logic    out_valid_reg;
    result_t result_reg, result_next;

    // Per-beat decode
    logic                 req_fire;
    logic                 is_report;
    logic                 at_stop;
    logic                 at_flush;
    logic                 fault_mid;
    logic                 tick_live;
    logic [FLUSH_W-1:0]   flush_mid;
    logic [ELAPSED_W-1:0] elapsed_inc;
    logic                 stop_cmd, flush_cmd, halt_cmd, resume_cmd, restart_cmd;

    assign req.ready = !out_valid_reg || rsp.ready;
    assign req_fire  = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    // Configuration writes; unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_level_reg    <= STOP_LEVEL_RST;
            flush_level_reg   <= FLUSH_LEVEL_RST;
            flush_limit_reg   <= FLUSH_LIMIT_RST;
            calm_needed_reg   <= CALM_NEEDED_RST;
            sleep_seconds_reg <= SLEEP_SECONDS_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg_index_t'(cfg.index))
                CFG_STOP_LEVEL:    stop_level_reg    <= $signed(cfg.data);
                CFG_FLUSH_LEVEL:   flush_level_reg   <= $signed(cfg.data);
                CFG_FLUSH_LIMIT:   flush_limit_reg   <= cfg.data[FLUSH_W-1:0];
                CFG_CALM_NEEDED:   calm_needed_reg   <= cfg.data[CALM_W-1:0];
                CFG_SLEEP_SECONDS: sleep_seconds_reg <= cfg.data[SLEEP_W-1:0];
                default: ;
            endcase
        end
    end

    // Decision logic for one beat.
    always_comb
    begin
        is_report = (req.req_type == REQ_LEVEL);
        at_stop   = is_report && (req.level >= stop_level_reg);
        at_flush  = req.level >= flush_level_reg;

        // High level: enter fault, clear the calm run, maybe flush.
        stop_cmd  = at_stop && !fault_reg;
        fault_mid = fault_reg || at_stop;
        flush_cmd = at_stop && at_flush && !asleep_reg;
        flush_mid = flush_reg;
        if (flush_cmd && (flush_reg != FLUSH_MAX))
        begin
            flush_mid = flush_reg + 1'b1;
        end
        halt_cmd = flush_cmd && (flush_mid >= flush_limit_reg);

        // Calm run counting, saturating.
        calm_next = calm_reg;
        if (at_stop)
        begin
            calm_next = '0;
        end
        else if (is_report && (calm_reg != CALM_MAX))
        begin
            calm_next = calm_reg + 1'b1;
        end
        resume_cmd = is_report && fault_mid && (calm_next >= calm_needed_reg);

        // Sleep timing on ticks.
        tick_live   = !is_report && asleep_reg;
        elapsed_inc = elapsed_reg;
        if (elapsed_reg != ELAPSED_MAX)
        begin
            elapsed_inc = elapsed_reg + 1'b1;
        end
        restart_cmd = tick_live && (elapsed_inc > {1'b0, sleep_seconds_reg});

        fault_next   = fault_mid && !resume_cmd;
        asleep_next  = halt_cmd ? 1'b1 : (restart_cmd ? 1'b0 : asleep_reg);
        flush_next   = (resume_cmd || restart_cmd) ? '0 : flush_mid;
        elapsed_next = halt_cmd ? '0 : (tick_live ? elapsed_inc : elapsed_reg);

        result_next.stop_motion     = stop_cmd;
        result_next.resume_motion   = resume_cmd;
        result_next.flush_request   = flush_cmd;
        result_next.halt_locator    = halt_cmd;
        result_next.restart_locator = restart_cmd;
        result_next.fault_active    = fault_next;
        result_next.locator_asleep  = asleep_next;
        result_next.flush_total     = flush_next;
    end

    // State update on each accepted beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fault_reg   <= 1'b0;
            asleep_reg  <= 1'b0;
            flush_reg   <= '0;
            calm_reg    <= '0;
            elapsed_reg <= '0;
        end
        else if (req_fire)
        begin
            fault_reg   <= fault_next;
            asleep_reg  <= asleep_next;
            flush_reg   <= flush_next;
            calm_reg    <= calm_next;
            elapsed_reg <= elapsed_next;
        end
    end

    // Result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (req_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            result_reg <= result_next;
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.stop_motion     = result_reg.stop_motion;
    assign rsp.resume_motion   = result_reg.resume_motion;
    assign rsp.flush_request   = result_reg.flush_request;
    assign rsp.halt_locator    = result_reg.halt_locator;
    assign rsp.restart_locator = result_reg.restart_locator;
    assign rsp.fault_active    = result_reg.fault_active;
    assign rsp.locator_asleep  = result_reg.locator_asleep;
    assign rsp.flush_total     = result_reg.flush_total;

    // A halt always leaves the locator asleep.
    a_halt_sleeps: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.halt_locator |-> result_reg.locator_asleep)
        else $error("halt without sleep");

    // A restart wakes the locator and clears the flush count.
    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.restart_locator
        |-> !result_reg.locator_asleep && (result_reg.flush_total == '0))
        else $error("restart left sleep or flush count");

    // A resume leaves the fault and clears the flush count.
    a_resume_clears: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.resume_motion
        |-> !result_reg.fault_active && (result_reg.flush_total == '0))
        else $error("resume left fault or flush count");

    // The supervisor state follows the last result it produced.
    a_state_matches: assert property (@(posedge clk) disable iff (!rst_n)
        $past(req_fire) |-> (fault_reg == result_reg.fault_active)
        && (asleep_reg == result_reg.locator_asleep) && (flush_reg == result_reg.flush_total))
        else $error("state and result disagree");

    // A waiting result that is not taken is never overwritten.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !rsp.ready |-> !req_fire)
        else $error("result overwritten");

endmodule
